// File: hw/rtl/gsa_pkg.sv
// Shared types and constants for the generational slot allocator.
// Used by gsa_ctrl, gsa_find, gsa_dp and generational_slot_allocator.
// No dependencies.
package gsa_pkg;

  // Table geometry
  localparam int unsigned SLOT_COUNT  = 128;
  localparam int unsigned SLOT_W      = $clog2(SLOT_COUNT);
  localparam int unsigned GEN_W       = 16;
  localparam int unsigned CNT_W       = $clog2(SLOT_COUNT + 1);
  localparam int unsigned FREE_W      = 8;
  localparam int unsigned FREE_MAX    = 255;

  // Free-slot search: groups of slots encoded in a first stage, groups in a second
  localparam int unsigned GROUP_W     = 16;
  localparam int unsigned GROUP_COUNT = SLOT_COUNT / GROUP_W;
  localparam int unsigned GROUP_IDX_W = $clog2(GROUP_COUNT);
  localparam int unsigned POS_W       = $clog2(GROUP_W);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CHECK = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_FIND = 2'd1,
    S_READ = 2'd2,
    S_DONE = 2'd3
  } state_e;

  typedef struct packed {
    op_e                operation;
    logic [SLOT_W-1:0]  slot_index;
    logic [GEN_W-1:0]   handle_generation;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  result_slot;
    logic [GEN_W-1:0]   result_generation;
    logic               handle_valid;
    status_e            status;
  } rsp_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch a new request
    logic find;     // register the per-group free-slot summary
    logic read;     // pick the slot and read its generation
    logic exec;     // update state and issue the result
  } cmd_t;

endpackage

// File: hw/rtl/gsa_ctrl.sv
// Controller state machine of the slot allocator.
// Sequences capture, search, memory read and execute; depends on gsa_pkg.
module gsa_ctrl
  import gsa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  // Busy while the search and the memory read are in progress
  assign busy   = (state_q == S_FIND) || (state_q == S_READ);
  assign accept = start && !busy;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.capture = accept;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_FIND;
      end
      S_FIND: begin
        cmd_o.find = 1'b1;
        state_d    = S_READ;
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        cmd_o.exec = 1'b1;
        state_d    = accept ? S_FIND : S_IDLE;
      end
    endcase
  end

  // Execute always follows the memory read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> $past(state_q == S_READ))
    else $error("execute without a preceding read");

  // An accepted request always starts a search next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == S_FIND))
    else $error("accepted request did not start a search");

endmodule

// File: hw/rtl/gsa_find.sv
// Two-stage priority encoder that finds the lowest free slot.
// Stage one is registered per group; stage two picks the group. Uses gsa_pkg.
module gsa_find
  import gsa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  find_en_i,
  input  logic [SLOT_COUNT-1:0] free_mask_i,
  output logic                  found_o,
  output logic [SLOT_W-1:0]     slot_o
);

  logic [GROUP_COUNT-1:0] grp_any_d, grp_any_q;
  logic [POS_W-1:0]       grp_pos_d [GROUP_COUNT];
  logic [POS_W-1:0]       grp_pos_q [GROUP_COUNT];

  function automatic logic [POS_W-1:0] lowest_pos(input logic [GROUP_W-1:0] bits);
    logic [POS_W-1:0] pos;
    pos = '0;
    for (int i = GROUP_W - 1; i >= 0; i--) begin
      if (bits[i]) pos = POS_W'(i);
    end
    return pos;
  endfunction

  // Encode each group of slots
  always_comb begin
    for (int g = 0; g < GROUP_COUNT; g++) begin
      grp_any_d[g] = |free_mask_i[g*GROUP_W +: GROUP_W];
      grp_pos_d[g] = lowest_pos(free_mask_i[g*GROUP_W +: GROUP_W]);
    end
  end

  // Hold the group summary for the pick stage
  always_ff @(posedge clk_i) begin
    if (find_en_i) begin
      grp_any_q <= grp_any_d;
      grp_pos_q <= grp_pos_d;
    end
  end

  // Pick the lowest group that has a free slot
  always_comb begin
    found_o = |grp_any_q;
    slot_o  = '0;
    for (int g = GROUP_COUNT - 1; g >= 0; g--) begin
      if (grp_any_q[g]) slot_o = {GROUP_IDX_W'(g), grp_pos_q[g]};
    end
  end

endmodule

// File: hw/rtl/gsa_dp.sv
// Datapath of the slot allocator: counters, occupied bits, generation memory.
// Driven by commands from gsa_ctrl; uses gsa_pkg and gsa_find.
module gsa_dp
  import gsa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  req_t req_i,
  output rsp_t rsp_o,
  output logic rsp_valid_o
);

  req_t                  req_q;
  logic [CNT_W-1:0]      hw_q, hw_d;
  logic [FREE_W-1:0]     free_q, free_d;
  logic [SLOT_COUNT-1:0] occ_q;
  logic [SLOT_COUNT-1:0] gvalid_q;
  logic [GEN_W-1:0]      gen_mem [SLOT_COUNT];

  logic                  pick_found;
  logic [SLOT_W-1:0]     pick_slot;
  logic                  alloc_new;
  logic                  sel_found;
  logic [SLOT_W-1:0]     sel_slot;

  logic [SLOT_W-1:0]     slot_q;
  logic                  found_q;
  logic                  new_q;
  logic                  in_range_q;
  logic                  occ_bit_q;
  logic [GEN_W-1:0]      rdata_q;
  logic                  rvalid_q;

  logic [GEN_W-1:0]      gen_cur;
  logic [GEN_W-1:0]      gen_inc;
  logic                  occ_we;
  logic                  occ_val;
  logic                  mem_we;
  rsp_t                  rsp_d, rsp_q;
  logic                  rsp_valid_q;

  // Latch the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) req_q <= req_i;
  end

  // Lowest free slot search
  gsa_find u_find (
    .clk_i       (clk_i),
    .find_en_i   (cmd_i.find),
    .free_mask_i (~occ_q),
    .found_o     (pick_found),
    .slot_o      (pick_slot)
  );

  // Choose the slot to work on
  assign alloc_new = hw_q < CNT_W'(SLOT_COUNT);

  always_comb begin
    sel_found = 1'b0;
    sel_slot  = req_q.slot_index;
    if (req_q.operation == OP_ALLOC) begin
      if (alloc_new) begin
        sel_found = 1'b1;
        sel_slot  = hw_q[SLOT_W-1:0];
      end else begin
        sel_found = (free_q != '0) && pick_found;
        sel_slot  = pick_slot;
      end
    end
  end

  // Read the generation memory and hold the slot facts
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      slot_q     <= sel_slot;
      found_q    <= sel_found;
      new_q      <= alloc_new;
      in_range_q <= CNT_W'(req_q.slot_index) < hw_q;
      occ_bit_q  <= occ_q[sel_slot];
      rdata_q    <= gen_mem[sel_slot];
      rvalid_q   <= gvalid_q[sel_slot];
    end
    if (mem_we) gen_mem[slot_q] <= gen_inc;
  end

  // A never-written generation reads as zero
  assign gen_cur = rvalid_q ? rdata_q : '0;
  assign gen_inc = gen_cur + GEN_W'(1);

  // Execute the operation
  always_comb begin
    hw_d    = hw_q;
    free_d  = free_q;
    occ_we  = 1'b0;
    occ_val = 1'b0;
    mem_we  = 1'b0;
    rsp_d   = '0;
    rsp_d.result_slot = slot_q;
    rsp_d.status      = STAT_OK;
    unique case (req_q.operation)
      OP_ALLOC: begin
        if (found_q) begin
          occ_we  = cmd_i.exec;
          occ_val = 1'b1;
          if (new_q) hw_d = hw_q + CNT_W'(1);
          else       free_d = free_q - FREE_W'(1);
          rsp_d.result_generation = gen_cur;
        end else begin
          rsp_d.result_slot = '0;
          rsp_d.status      = STAT_FULL;
        end
      end
      OP_FREE: begin
        if (in_range_q) begin
          mem_we  = cmd_i.exec;
          occ_we  = cmd_i.exec;
          occ_val = 1'b0;
          if (free_q != FREE_W'(FREE_MAX)) free_d = free_q + FREE_W'(1);
          rsp_d.result_generation = gen_inc;
        end else begin
          rsp_d.status = STAT_RANGE;
        end
      end
      OP_CHECK: begin
        rsp_d.result_generation = gen_cur;
        rsp_d.handle_valid = in_range_q && occ_bit_q && (gen_cur == req_q.handle_generation);
      end
      OP_NONE: begin
        rsp_d.result_slot = slot_q;
      end
    endcase
  end

  // Control state: counters, occupied and generation-valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q        <= '0;
      free_q      <= '0;
      occ_q       <= '0;
      gvalid_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= cmd_i.exec;
      if (cmd_i.exec) begin
        hw_q   <= hw_d;
        free_q <= free_d;
      end
      if (occ_we) occ_q[slot_q] <= occ_val;
      if (mem_we) gvalid_q[slot_q] <= 1'b1;
    end
  end

  // Register the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) rsp_q <= rsp_d;
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

  // Counters move only on execute
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.exec |=> ($stable(hw_q) && $stable(free_q)))
    else $error("counter changed outside execute");

  // A reused slot must have been free when picked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && req_q.operation == OP_ALLOC && found_q && !new_q) |-> !occ_bit_q)
    else $error("allocated a slot that was occupied");

  // A full report carries no slot and no generation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_q.status == STAT_FULL)
      |-> (rsp_q.result_slot == '0 && rsp_q.result_generation == '0))
    else $error("full result carries a slot");

endmodule

// File: hw/rtl/generational_slot_allocator.sv
// Generational slot allocator: allocate, free and check handles in a slot table.
// Flow: an accepted request passes search, memory read and execute; the result is registered.
// A new operation is refused while the registered free-slot search stage and the
// registered generation memory read are in progress; execute can accept the next one.
// Reset: counters, occupied bits and generation-valid flags clear at once, no sweep.
// Results cannot be stalled; each is strobed by rsp_valid_o for exactly one cycle.
module generational_slot_allocator
  import gsa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output rsp_t rsp_o,
  output logic rsp_valid_o
);

  cmd_t cmd;

  // Sequencer
  gsa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  // Table state and result formation
  gsa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .rsp_valid_o (rsp_valid_o)
  );

endmodule

// File: sim/generational_slot_allocator_tb.sv
// Self-checking testbench for generational_slot_allocator: allocate, free and check transfers
// against an in-bench slot table predictor, with random idle bursts on the command side.
// Depends on gsa_pkg and the generational_slot_allocator RTL.
module generational_slot_allocator_tb
  import gsa_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  rsp_t rsp_o;
  logic rsp_valid_o;

  generational_slot_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .rsp_valid_o (rsp_valid_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the slot table
  logic                slot_busy [SLOT_COUNT];
  logic [GEN_W-1:0]    slot_gen  [SLOT_COUNT];
  int unsigned         hw_mark;
  logic [FREE_W-1:0]   free_tally;

  req_t op_backlog [$];
  rsp_t pending_rsp [$];
  rsp_t rsp_want;
  int   issued;
  int   accepted;
  int   gap_left;
  bit   idle_on;
  int   mismatches;
  int   n_results;
  int   n_full;
  int   n_range;
  int   n_hits;

  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_busy[i] = 1'b0;
      slot_gen[i]  = '0;
    end
    hw_mark    = 0;
    free_tally = '0;
  end

  // Apply one accepted transfer to the shadow table and return the response it must produce
  function automatic rsp_t advance_table(req_t r);
    rsp_t        o;
    int unsigned s;
    bit          hit;
    o = '0;
    o.result_slot = r.slot_index;
    o.status = STAT_OK;
    case (r.operation)
      OP_ALLOC: begin
        hit = 1'b0;
        s = 0;
        if (hw_mark < SLOT_COUNT) begin
          s = hw_mark;
          hw_mark++;
          hit = 1'b1;
        end else if (free_tally != '0) begin
          // lowest unoccupied slot; a stale free count may find none
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!hit && !slot_busy[i]) begin
              s = i;
              hit = 1'b1;
            end
          end
          if (hit) free_tally--;
        end
        if (hit) begin
          slot_busy[s] = 1'b1;
          o.result_slot = s[SLOT_W-1:0];
          o.result_generation = slot_gen[s];
        end else begin
          o.result_slot = '0;
          o.status = STAT_FULL;
        end
      end
      OP_FREE: begin
        if (int'(r.slot_index) >= int'(hw_mark)) begin
          o.status = STAT_RANGE;
        end else begin
          slot_gen[r.slot_index] = slot_gen[r.slot_index] + 1'b1;
          slot_busy[r.slot_index] = 1'b0;
          if (free_tally != FREE_MAX[FREE_W-1:0]) free_tally++;
          o.result_generation = slot_gen[r.slot_index];
        end
      end
      OP_CHECK: begin
        o.result_generation = slot_gen[r.slot_index];
        o.handle_valid = (int'(r.slot_index) < int'(hw_mark)) && slot_busy[r.slot_index] &&
                         (slot_gen[r.slot_index] == r.handle_generation);
      end
      default: ;
    endcase
    return o;
  endfunction

  // Driver: hold start until the transfer is taken, insert idle bursts between transfers
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        pending_rsp.push_back(advance_table(req_i));
        accepted++;
      end
      if (start && busy) begin
        // hold the current transfer
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (op_backlog.size() != 0 && idle_on && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(1, 11) - 1;
        start <= 1'b0;
      end else if (op_backlog.size() != 0) begin
        req_i <= op_backlog.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each strobed result with the oldest expected response
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o === 1'b1) begin
      if (pending_rsp.size() == 0) begin
        $error("result strobe with no transfer outstanding: slot %0d", rsp_o.result_slot);
        mismatches++;
      end else begin
        rsp_want = pending_rsp.pop_front();
        n_results++;
        if (rsp_want.status == STAT_FULL) n_full++;
        if (rsp_want.status == STAT_RANGE) n_range++;
        if (rsp_want.handle_valid) n_hits++;
        if (rsp_o.result_slot !== rsp_want.result_slot) begin
          $error("result_slot: expected %0d, got %0d", rsp_want.result_slot, rsp_o.result_slot);
          mismatches++;
        end
        if (rsp_o.result_generation !== rsp_want.result_generation) begin
          $error("result_generation: expected %0d, got %0d",
                 rsp_want.result_generation, rsp_o.result_generation);
          mismatches++;
        end
        if (rsp_o.handle_valid !== rsp_want.handle_valid) begin
          $error("handle_valid: expected %0d, got %0d", rsp_want.handle_valid,
                 rsp_o.handle_valid);
          mismatches++;
        end
        if (rsp_o.status !== rsp_want.status) begin
          $error("status: expected %0d, got %0d", rsp_want.status, rsp_o.status);
          mismatches++;
        end
      end
    end
  end

  task automatic queue_op(op_e op, logic [SLOT_W-1:0] slot, logic [GEN_W-1:0] hgen);
    req_t r;
    while (op_backlog.size() >= 2) @(posedge clk_i);
    r.operation = op;
    r.slot_index = slot;
    r.handle_generation = hgen;
    op_backlog.push_back(r);
    issued++;
  endtask

  // Wait until every queued transfer is taken and its result has come back
  task automatic settle();
    while (accepted != issued || pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  // Random slot below the high-water mark whose occupied bit matches, else any slot
  function automatic logic [SLOT_W-1:0] pick_slot(bit want_busy);
    int base;
    int s;
    base = $urandom_range(0, SLOT_COUNT - 1);
    for (int i = 0; i < SLOT_COUNT; i++) begin
      s = (base + i) % SLOT_COUNT;
      if (s < int'(hw_mark) && slot_busy[s] == want_busy) return s[SLOT_W-1:0];
    end
    return base[SLOT_W-1:0];
  endfunction

  // Mostly well-formed handles, with stale, random and unused-code noise mixed in
  task automatic queue_random_op();
    int               r;
    int               g;
    logic [SLOT_W-1:0] s;
    logic [GEN_W-1:0]  hg;
    r = $urandom_range(0, 99);
    s = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
    hg = GEN_W'($urandom_range(0, 16'hFFFF));
    if (r < 30) begin
      queue_op(OP_ALLOC, s, hg);
    end else if (r < 55) begin
      if ($urandom_range(0, 3) != 0) s = pick_slot(1'b1);
      queue_op(OP_FREE, s, hg);
    end else if (r < 92) begin
      if ($urandom_range(0, 4) < 3) s = pick_slot(1'b1);
      g = $urandom_range(0, 99);
      if (g < 60) hg = slot_gen[s];
      else if (g < 75) hg = slot_gen[s] - 1'b1;
      queue_op(OP_CHECK, s, hg);
    end else if (r < 97) begin
      queue_op(OP_NONE, s, hg);
    end else begin
      queue_op(OP_FREE, s, hg);
    end
  endtask

  initial begin : stimulus
    int granted;
    logic [SLOT_W-1:0] s;
    idle_on = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table: everything is out of range, unused code echoes the slot
    queue_op(OP_CHECK, 0, 0);
    queue_op(OP_FREE, 127, 0);
    queue_op(OP_FREE, 0, 16'hFFFF);
    queue_op(OP_NONE, 127, 16'hFFFF);
    queue_op(OP_NONE, 0, 0);
    // First allocations ignore the request fields
    queue_op(OP_ALLOC, 127, 16'hFFFF);
    queue_op(OP_ALLOC, 0, 0);
    queue_op(OP_CHECK, 0, 0);
    queue_op(OP_CHECK, 0, 16'hFFFF);
    queue_op(OP_CHECK, 1, 16'h0001);
    queue_op(OP_CHECK, 2, 0);
    queue_op(OP_CHECK, 127, 16'hFFFF);
    // Free takes any handle generation; the old handle goes stale
    queue_op(OP_FREE, 1, 16'hABCD);
    queue_op(OP_CHECK, 1, 0);
    queue_op(OP_CHECK, 1, 1);
    queue_op(OP_FREE, 2, 0);
    queue_op(OP_ALLOC, 0, 0);
    queue_op(OP_CHECK, 2, 0);
    queue_op(OP_NONE, 85, 16'h5555);
    granted = 3;

    // Fill to the high-water limit; frees only hit occupied slots so the free count stays exact
    while (granted < SLOT_COUNT) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          queue_op(OP_ALLOC, SLOT_W'($urandom_range(0, SLOT_COUNT - 1)),
                   GEN_W'($urandom_range(0, 16'hFFFF)));
          granted++;
        end
        5, 6: begin
          settle();
          s = pick_slot(1'b1);
          queue_op(OP_FREE, s, GEN_W'($urandom_range(0, 16'hFFFF)));
        end
        default: begin
          s = pick_slot(1'b1);
          queue_op(OP_CHECK, s, slot_gen[s]);
        end
      endcase
    end

    // Reclaim every freed slot, then hit a truly full table
    settle();
    repeat (int'(free_tally) + 2) queue_op(OP_ALLOC, 0, 0);
    settle();

    // Random traffic on a full-size table, with stretches without idle bursts
    for (int k = 0; k < 250; k++) begin
      idle_on = ((k / 50) % 3) != 1;
      queue_random_op();
    end

    // Free one slot over and over; the extra frees inflate the free count
    settle();
    idle_on = 1'b1;
    queue_op(OP_CHECK, 5, slot_gen[5]);
    repeat (60) queue_op(OP_FREE, 5, GEN_W'($urandom_range(0, 16'hFFFF)));
    settle();
    queue_op(OP_CHECK, 5, slot_gen[5]);
    queue_op(OP_ALLOC, 0, 0);
    queue_op(OP_ALLOC, 0, 0);
    settle();
    queue_op(OP_CHECK, 5, slot_gen[5]);
    queue_op(OP_CHECK, 5, slot_gen[5] + 1'b1);

    // Closing stretch at full rate
    idle_on = 1'b0;
    repeat (80) queue_random_op();
    settle();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d transfers, %0d results: %0d table full, %0d out-of-range frees,",
             issued, n_results, n_full, n_range);
    $display("%0d live handles, repeated frees of slot 5, final free count %0d",
             n_hits, free_tally);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/gsa_pkg.sv
hw/rtl/gsa_ctrl.sv
hw/rtl/gsa_find.sv
hw/rtl/gsa_dp.sv
hw/rtl/generational_slot_allocator.sv
sim/generational_slot_allocator_tb.sv
